[design/ans_pkg.sv]
// ----------------------------------------------------------------------------
// Automaton note sequencer package
// Shared types, command codes and constants of the note sequencer.
// ----------------------------------------------------------------------------
package ans_pkg;

    localparam int GRID_ROWS  = 8;
    localparam int NUM_VOICES = 8;
    localparam int STEP_W     = $clog2(NUM_VOICES);
    localparam int ROW_W      = 8;
    localparam int NOTE_W     = 7;
    localparam int CHAN_W     = 4;
    localparam int CNT_W      = $clog2(ROW_W + 1);
    localparam int CMD_W      = 4;
    localparam int IDX_W      = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ROOT_W     = NUM_VOICES * NOTE_W;
    localparam int PMASK_W    = NUM_VOICES * ROW_W;
    localparam int CHANS_W    = NUM_VOICES * CHAN_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef logic [NOTE_W-1:0] note_t;
    typedef logic [ROW_W-1:0]  row_t;

    localparam row_t EVEN_CELLS = 8'b1010_1010;
    localparam row_t ODD_CELLS  = 8'b0101_0101;

    localparam logic [ROOT_W-1:0]  ROOT_RESET  = 56'd20426916942061372;
    localparam logic [PMASK_W-1:0] PMASK_RESET = 64'hFFFF_0000_0000_0000;
    localparam logic [CHANS_W-1:0] CHANS_RESET = 32'h0099_9999;

    // Pitch offset of each masked bit; bit 0 lowers the note, the rest raise it.
    localparam note_t PITCH_WEIGHT [ROW_W] =
        '{7'd12, 7'd12, 7'd7, 7'd5, 7'd3, 7'd2, 7'd2, 7'd1};

    localparam note_t HELD_RESET [NUM_VOICES] =
        '{7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd69, 7'd36, 7'd36};

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK          = 4'd0,
        CMD_TOGGLE_CELL   = 4'd1,
        CMD_TOGGLE_ACTIVE = 4'd2,
        CMD_TOGGLE_DOUBLE = 4'd3,
        CMD_TOGGLE_RUN    = 4'd4,
        CMD_CLEAR         = 4'd5,
        CMD_WRITE_ROW     = 4'd6,
        CMD_UP            = 4'd7,
        CMD_DOWN          = 4'd8,
        CMD_LEFT          = 4'd9,
        CMD_RIGHT         = 4'd10,
        CMD_BUMP_TIME     = 4'd11
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT_NOTES  = 2'd0,
        CFG_PITCH_MASKS = 2'd1,
        CFG_CHANNELS    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        GOP_NONE,
        GOP_TOGGLE,
        GOP_CLEAR,
        GOP_WRITE,
        GOP_UP,
        GOP_DOWN,
        GOP_LEFT,
        GOP_RIGHT,
        GOP_ROTATE,
        GOP_EVOLVE
    } grid_op_t;

    typedef struct packed {
        grid_op_t         op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        row_t             bits;
        row_t             sel;
    } grid_ctl_t;

    typedef struct packed {
        note_t note;
        note_t velocity;
    } voice_evt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NOTES,
        ST_EVOLVE
    } state_t;

endpackage

[design/automaton_note_sequencer.sv]
// ----------------------------------------------------------------------------
// Automaton note sequencer
// Cellular-automaton grid that plays one note stream per grid row.
// ----------------------------------------------------------------------------
// Input items are taken only while s_axis_tready is high. Grid edits, mode
// toggles and time bumps finish in the cycle they are accepted. A tick while
// running walks the eight instruments, then runs one or two grid updates;
// the single row-update unit works on the head row while the grid rotates by
// one row a cycle. Stopping or deactivating a sounding instrument walks the
// instruments. The instrument walk waits whenever a note event is due and
// the output register is still full. Configuration writes take effect at
// once and must be made while idle.
module automaton_note_sequencer #(
    parameter int GRID_ROWS = ans_pkg::GRID_ROWS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [ans_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ans_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Command items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // command[3:0], row[6:4], column[9:7], row_bits[17:10], zero pad
    input  logic [ans_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // Note event items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // channel[3:0], note[10:4], velocity[17:11], zero pad
    output logic [ans_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import ans_pkg::*;

    state_t                state_reg,   state_next;
    logic [STEP_W-1:0]     step_reg,    step_next;
    logic                  pass_reg,    pass_next;
    logic                  tick_reg,    tick_next;
    logic [NUM_VOICES-1:0] ev_mask_reg, ev_mask_next;
    logic [NUM_VOICES-1:0] sounding_reg, sounding_next;
    logic [NUM_VOICES-1:0] active_reg,  active_next;
    note_t                 held_reg  [NUM_VOICES];
    note_t                 held_next [NUM_VOICES];
    logic                  double_reg,  double_next;
    logic                  run_reg,     run_next;
    logic                  parity_reg,  parity_next;

    logic [ROOT_W-1:0]     root_reg;
    logic [PMASK_W-1:0]    pmask_reg;
    logic [CHANS_W-1:0]    chan_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]     out_chan_reg,  out_chan_next;
    note_t                 out_note_reg,  out_note_next;
    note_t                 out_vel_reg,   out_vel_next;
    logic                  out_last_reg,  out_last_next;

    cmd_t                  command;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      column;
    row_t                  row_bits;
    logic                  s_accept;
    logic                  out_free;
    logic [NUM_VOICES-1:0] row_onehot;
    logic [NUM_VOICES-1:0] later_events;
    logic                  ev_here;

    grid_ctl_t             grid_ctl;
    row_t                  head_row;
    logic [GRID_ROWS-1:0]  row_parity;
    voice_evt_t            voice_evt;

    assign command  = cmd_t'(s_axis_tdata[3:0]);
    assign row      = s_axis_tdata[6:4];
    assign column   = s_axis_tdata[9:7];
    assign row_bits = s_axis_tdata[17:10];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign row_onehot    = NUM_VOICES'(1) << row;
    assign ev_here       = ev_mask_reg[step_reg];
    assign later_events  = (ev_mask_reg >> step_reg) >> 1;

    ans_grid #(
        .GRID_ROWS (GRID_ROWS)
    ) u_grid (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (grid_ctl),
        .head_row   (head_row),
        .row_parity (row_parity)
    );

    ans_voice u_voice (
        .head_row   (head_row),
        .pitch_mask (pmask_reg[ROW_W*step_reg +: ROW_W]),
        .root_note  (root_reg[NOTE_W*step_reg +: NOTE_W]),
        .evt        (voice_evt)
    );

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        pass_next     = pass_reg;
        tick_next     = tick_reg;
        ev_mask_next  = ev_mask_reg;
        sounding_next = sounding_reg;
        active_next   = active_reg;
        for (int k = 0; k < NUM_VOICES; k++)
        begin
            held_next[k] = held_reg[k];
        end
        double_next   = double_reg;
        run_next      = run_reg;
        parity_next   = parity_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_chan_next  = out_chan_reg;
        out_note_next  = out_note_reg;
        out_vel_next   = out_vel_reg;
        out_last_next  = out_last_reg;

        grid_ctl.op   = GOP_NONE;
        grid_ctl.row  = row;
        grid_ctl.col  = column;
        grid_ctl.bits = row_bits;
        grid_ctl.sel  = (parity_reg ^ step_reg[0]) ? ODD_CELLS : EVEN_CELLS;

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_accept)
                begin
                    unique case (command)
                        CMD_TICK:
                        begin
                            if (run_reg)
                            begin
                                // Odd rows that are silent start, even rows that sound stop.
                                ev_mask_next = active_reg & (row_parity ^ sounding_reg);
                                tick_next    = 1'b1;
                                state_next   = ST_NOTES;
                            end
                        end
                        CMD_TOGGLE_CELL:   grid_ctl.op = GOP_TOGGLE;
                        CMD_TOGGLE_ACTIVE:
                        begin
                            active_next  = active_reg ^ row_onehot;
                            ev_mask_next = sounding_reg & row_onehot;
                            tick_next    = 1'b0;
                            if (|(sounding_reg & row_onehot))
                            begin
                                state_next = ST_NOTES;
                            end
                        end
                        CMD_TOGGLE_DOUBLE: double_next = !double_reg;
                        CMD_TOGGLE_RUN:
                        begin
                            run_next     = !run_reg;
                            ev_mask_next = sounding_reg;
                            tick_next    = 1'b0;
                            if (run_reg && |sounding_reg)
                            begin
                                state_next = ST_NOTES;
                            end
                        end
                        CMD_CLEAR:         grid_ctl.op = GOP_CLEAR;
                        CMD_WRITE_ROW:     grid_ctl.op = GOP_WRITE;
                        CMD_UP:
                        begin
                            grid_ctl.op = GOP_UP;
                            parity_next = !parity_reg;
                        end
                        CMD_DOWN:
                        begin
                            grid_ctl.op = GOP_DOWN;
                            parity_next = !parity_reg;
                        end
                        CMD_LEFT:
                        begin
                            grid_ctl.op = GOP_LEFT;
                            parity_next = !parity_reg;
                        end
                        CMD_RIGHT:
                        begin
                            grid_ctl.op = GOP_RIGHT;
                            parity_next = !parity_reg;
                        end
                        CMD_BUMP_TIME:     parity_next = !parity_reg;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NOTES:
            begin
                // The grid turns one row per step so that row i is at the head.
                if (!ev_here || out_free)
                begin
                    grid_ctl.op = GOP_ROTATE;
                    if (ev_here)
                    begin
                        out_valid_next = 1'b1;
                        out_chan_next  = chan_reg[CHAN_W*step_reg +: CHAN_W];
                        out_last_next  = (later_events == '0);
                        if (sounding_reg[step_reg])
                        begin
                            out_note_next           = held_reg[step_reg];
                            out_vel_next            = '0;
                            sounding_next[step_reg] = 1'b0;
                        end
                        else
                        begin
                            out_note_next           = voice_evt.note;
                            out_vel_next            = voice_evt.velocity;
                            held_next[step_reg]     = voice_evt.note;
                            sounding_next[step_reg] = 1'b1;
                        end
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_W'(NUM_VOICES - 1))
                    begin
                        if (tick_reg)
                        begin
                            parity_next = !parity_reg;
                            pass_next   = double_reg;
                            state_next  = ST_EVOLVE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EVOLVE:
            begin
                grid_ctl.op = GOP_EVOLVE;
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(GRID_ROWS - 1))
                begin
                    if (pass_reg)
                    begin
                        parity_next = !parity_reg;
                        pass_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            tick_reg      <= 1'b0;
            ev_mask_reg   <= '0;
            sounding_reg  <= '0;
            active_reg    <= '1;
            for (int k = 0; k < NUM_VOICES; k++)
            begin
                held_reg[k] <= HELD_RESET[k];
            end
            double_reg    <= 1'b1;
            run_reg       <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            tick_reg      <= tick_next;
            ev_mask_reg   <= ev_mask_next;
            sounding_reg  <= sounding_next;
            active_reg    <= active_next;
            for (int k = 0; k < NUM_VOICES; k++)
            begin
                held_reg[k] <= held_next[k];
            end
            double_reg    <= double_next;
            run_reg       <= run_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_chan_reg <= out_chan_next;
        out_note_reg <= out_note_next;
        out_vel_reg  <= out_vel_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= ROOT_RESET;
            pmask_reg <= PMASK_RESET;
            chan_reg  <= CHANS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROOT_NOTES:  root_reg  <= cfg_data[ROOT_W-1:0];
                CFG_PITCH_MASKS: pmask_reg <= cfg_data[PMASK_W-1:0];
                CFG_CHANNELS:    chan_reg  <= cfg_data[CHANS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CHAN_W - 2*NOTE_W){1'b0}},
                            out_vel_reg, out_note_reg, out_chan_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[design/ans_grid.sv]
// ----------------------------------------------------------------------------
// Grid store
// Toroidal bit grid with row edits, shifts and a one-row update unit that
// works on the head row while the whole grid rotates by one row a cycle.
// ----------------------------------------------------------------------------
module ans_grid #(
    parameter int GRID_ROWS = ans_pkg::GRID_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ans_pkg::grid_ctl_t     ctl,
    output ans_pkg::row_t          head_row,
    output logic [GRID_ROWS-1:0]   row_parity
);
    import ans_pkg::*;

    row_t rows_reg  [GRID_ROWS];
    row_t rows_next [GRID_ROWS];

    row_t cur;
    row_t up_row;
    row_t dn_row;
    row_t rot_l;
    row_t rot_r;
    row_t two;
    row_t new_head;

    // Rows above and below the head sit at fixed places of the rotating grid.
    // Once row 0 has gone around, the row below row 7 is already updated.
    always_comb
    begin
        cur      = rows_reg[0];
        up_row   = rows_reg[GRID_ROWS-1];
        dn_row   = rows_reg[1];
        rot_l    = {cur[ROW_W-2:0], cur[ROW_W-1]};
        rot_r    = {cur[0], cur[ROW_W-1:1]};
        two      = ~((up_row ^ dn_row ^ rot_l ^ rot_r) | (up_row & dn_row & rot_l & rot_r))
                   & (up_row | dn_row | rot_l | rot_r);
        new_head = cur ^ (two & ctl.sel);
    end

    always_comb
    begin
        for (int k = 0; k < GRID_ROWS; k++)
        begin
            rows_next[k] = rows_reg[k];
        end
        unique case (ctl.op)
            GOP_NONE:
            begin
            end
            GOP_TOGGLE:
            begin
                rows_next[ctl.row] = rows_reg[ctl.row] ^ (row_t'(1) << ctl.col);
            end
            GOP_CLEAR:
            begin
                for (int k = 0; k < GRID_ROWS; k++)
                begin
                    rows_next[k] = '0;
                end
            end
            GOP_WRITE:
            begin
                rows_next[ctl.row] = ctl.bits;
            end
            GOP_UP:
            begin
                rows_next[0] = rows_reg[GRID_ROWS-1];
                for (int k = 1; k < GRID_ROWS; k++)
                begin
                    rows_next[k] = rows_reg[k-1];
                end
            end
            GOP_DOWN, GOP_ROTATE:
            begin
                for (int k = 0; k < GRID_ROWS - 1; k++)
                begin
                    rows_next[k] = rows_reg[k+1];
                end
                rows_next[GRID_ROWS-1] = rows_reg[0];
            end
            GOP_LEFT:
            begin
                for (int k = 0; k < GRID_ROWS; k++)
                begin
                    rows_next[k] = {rows_reg[k][0], rows_reg[k][ROW_W-1:1]};
                end
            end
            GOP_RIGHT:
            begin
                for (int k = 0; k < GRID_ROWS; k++)
                begin
                    rows_next[k] = {rows_reg[k][ROW_W-2:0], rows_reg[k][ROW_W-1]};
                end
            end
            GOP_EVOLVE:
            begin
                for (int k = 0; k < GRID_ROWS - 1; k++)
                begin
                    rows_next[k] = rows_reg[k+1];
                end
                rows_next[GRID_ROWS-1] = new_head;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < GRID_ROWS; k++)
            begin
                rows_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < GRID_ROWS; k++)
            begin
                rows_reg[k] <= rows_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < GRID_ROWS; k++)
        begin
            row_parity[k] = ^rows_reg[k];
        end
    end

    assign head_row = rows_reg[0];

endmodule

[design/ans_voice.sv]
// ----------------------------------------------------------------------------
// Voice unit
// Pitch and note-on velocity of the instrument whose row is at the grid head.
// ----------------------------------------------------------------------------
module ans_voice (
    input  ans_pkg::row_t       head_row,
    input  ans_pkg::row_t       pitch_mask,
    input  ans_pkg::note_t      root_note,
    output ans_pkg::voice_evt_t evt
);
    import ans_pkg::*;

    row_t             picked;
    note_t            pitch;
    logic [CNT_W-1:0] count;

    always_comb
    begin
        picked = head_row & pitch_mask;
        pitch  = root_note;
        if (picked[0])
        begin
            pitch = pitch - PITCH_WEIGHT[0];
        end
        for (int b = 1; b < ROW_W; b++)
        begin
            if (picked[b])
            begin
                pitch = pitch + PITCH_WEIGHT[b];
            end
        end

        count = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            count = count + CNT_W'(head_row[b]);
        end
    end

    // A note-on only happens on an odd count, so 16 times it fits in 7 bits.
    assign evt.note     = pitch;
    assign evt.velocity = {count[2:0], 4'b0000};

endmodule

[design/ans_checker.sv]
// ----------------------------------------------------------------------------
// Note sequencer port checker
// Checks what the sequencer ports show over time; bound to the top level.
// ----------------------------------------------------------------------------
module ans_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ans_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ans_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);
    import ans_pkg::*;

    // A stalled note event holds its value and its end-of-burst mark.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("note event changed while stalled");

    // Velocity is zero for a note-off or sixteen times an odd count.
    a_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid
        |-> m_axis_tdata[14:11] == 4'd0
            && (m_axis_tdata[17:11] == 7'd0 || m_axis_tdata[15]))
        else $error("velocity is not a note-off or an odd multiple of 16");

    // Commands that only edit the grid or a mode leave the block ready.
    a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tdata[3:0] == CMD_TOGGLE_DOUBLE || s_axis_tdata[3:0] == CMD_TOGGLE_CELL
            || s_axis_tdata[3:0] == CMD_WRITE_ROW || s_axis_tdata[3:0] == CMD_CLEAR)
        |=> s_axis_tready)
        else $error("grid or mode command left the block busy");

endmodule

bind automaton_note_sequencer ans_checker u_ans_checker (.*);
